// File: rtl/dnsd_pkg.sv
// dnsd_pkg: payload types, command/status structs and constants of the dns name decompressor
// used by every module under rtl/ but dnsd_ram; depends on nothing
`timescale 1ns / 1ps

package dnsd_pkg;

  // operation codes of an input item
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_OOB  = 2'd1;
  localparam logic [1:0] STATUS_HOPS = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT  = 1'd1;

  // register reset values
  localparam logic [9:0] PACKET_LENGTH_RST = 10'd512;
  localparam logic [8:0] OUTPUT_LIMIT_RST  = 9'd256;

  // encoding constants
  localparam logic [7:0]  PTR_MARK = 8'hC0;
  localparam logic [15:0] PTR_MASK = 16'h3FFF;
  localparam logic [7:0]  DOT_CHAR = 8'h2E;

  // input item
  typedef struct packed {
    logic       op;
    logic [8:0] byte_address;
    logic [7:0] byte_value;
    logic [8:0] start_offset;
  } dnsd_in_t;

  // result item
  typedef struct packed {
    logic [63:0] name_chunk;
    logic [3:0]  chunk_bytes;
    logic        last;
    logic [1:0]  status;
    logic [9:0]  resume_offset;
  } dnsd_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load_wr;      // write one packet byte
    logic       start;        // init a walk
    logic       len_rd;       // read length byte at pos
    logic       ptr_rd;       // read second pointer byte
    logic       ptr_take;     // jump to pointer target
    logic       label_start;  // begin label copy, insert dot
    logic       copy_rd;      // read one label byte
    logic       term;         // terminating zero seen
    logic       emit_init;    // rewind text read index
    logic       chunk_clear;  // start a new chunk
    logic       fill_rd;      // read one text byte into chunk
    logic       push;         // load output register
    logic       set_err;      // record an error
    logic [1:0] err_code;
  } dnsd_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic pos_oob;
    logic is_zero;
    logic is_ptr;
    logic ptr_oob;
    logic hop_lim;
    logic label_oob;
    logic cnt_last;
    logic fill_more;
    logic done;
    logic out_free;
  } dnsd_sts_t;

endpackage

// File: rtl/dnsd_ram.sv
// dnsd_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module dnsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/dnsd_ctrl.sv
// dnsd_ctrl: controller state machine of the name walk and the chunk emission
// depends on dnsd_pkg; drives the datapath in dnsd_dp
`timescale 1ns / 1ps

module dnsd_ctrl
  import dnsd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_op_i,
  output logic      busy_o,
  input  dnsd_sts_t sts_i,
  output dnsd_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_LENW,
    ST_PTRW,
    ST_COPY,
    ST_FILL,
    ST_PUSH
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;
  logic   in_acc;

  assign in_acc = in_valid_i && !busy_q;

  // next state and commands
  always_comb begin
    state_d = state_q;
    busy_d  = busy_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_op_i == OP_LOAD) begin
          cmd_o.load_wr = 1'b1;
        end else if (in_acc) begin
          cmd_o.start = 1'b1;
          busy_d      = 1'b1;
          state_d     = ST_LEN;
        end
      end
      ST_LEN: begin
        if (sts_i.pos_oob) begin
          cmd_o.set_err  = 1'b1;
          cmd_o.err_code = STATUS_OOB;
          state_d        = ST_PUSH;
        end else begin
          cmd_o.len_rd = 1'b1;
          state_d      = ST_LENW;
        end
      end
      ST_LENW: begin
        if (sts_i.is_zero) begin
          cmd_o.term        = 1'b1;
          cmd_o.emit_init   = 1'b1;
          cmd_o.chunk_clear = 1'b1;
          state_d           = ST_FILL;
        end else if (sts_i.is_ptr) begin
          if (sts_i.ptr_oob) begin
            cmd_o.set_err  = 1'b1;
            cmd_o.err_code = STATUS_OOB;
            state_d        = ST_PUSH;
          end else if (sts_i.hop_lim) begin
            cmd_o.set_err  = 1'b1;
            cmd_o.err_code = STATUS_HOPS;
            state_d        = ST_PUSH;
          end else begin
            cmd_o.ptr_rd = 1'b1;
            state_d      = ST_PTRW;
          end
        end else if (sts_i.label_oob) begin
          cmd_o.set_err  = 1'b1;
          cmd_o.err_code = STATUS_OOB;
          state_d        = ST_PUSH;
        end else begin
          cmd_o.label_start = 1'b1;
          state_d           = ST_COPY;
        end
      end
      ST_PTRW: begin
        cmd_o.ptr_take = 1'b1;
        state_d        = ST_LEN;
      end
      ST_COPY: begin
        cmd_o.copy_rd = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ST_LEN;
        end
      end
      ST_FILL: begin
        if (sts_i.fill_more) begin
          cmd_o.fill_rd = 1'b1;
        end else begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          if (sts_i.done) begin
            busy_d  = 1'b0;
            state_d = ST_IDLE;
          end else begin
            cmd_o.chunk_clear = 1'b1;
            state_d           = ST_FILL;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
        busy_d  = 1'b0;
      end
    endcase
  end

  // state and registered busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy_o = busy_q;

  // busy exactly while a decode is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) == !busy_q)
    else $error("busy flag out of step with state");

  // a plain in-bounds length byte always starts a copy run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LENW && !sts_i.is_zero && !sts_i.is_ptr && !sts_i.label_oob)
      |=> state_q == ST_COPY)
    else $error("label copy not entered");

  // a final push always returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.push && sts_i.done) |=> !busy_q)
    else $error("decode did not finish after final push");

endmodule

// File: rtl/dnsd_dp.sv
// dnsd_dp: datapath with packet store, text buffer, walk registers and output register
// depends on dnsd_pkg and dnsd_ram; commanded by dnsd_ctrl
`timescale 1ns / 1ps

module dnsd_dp
  import dnsd_pkg::*;
#(
  parameter int unsigned PACKET_BYTES = 512,
  parameter int unsigned NAME_MAX     = 256,
  parameter int unsigned MAX_HOPS     = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  dnsd_in_t              in_data_i,
  input  dnsd_cmd_t             cmd_i,
  output dnsd_sts_t             sts_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output dnsd_out_t             out_data_o
);

  localparam int unsigned AW = $clog2(PACKET_BYTES);
  localparam int unsigned PW = (AW + 1 > 14) ? AW + 1 : 14;
  localparam int unsigned CW = PW + 1;
  localparam int unsigned TW = $clog2(NAME_MAX);
  localparam int unsigned HW = $clog2(MAX_HOPS + 1);

  // configuration registers
  logic [9:0] packet_length_q;
  logic [8:0] output_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      packet_length_q <= PACKET_LENGTH_RST;
      output_limit_q  <= OUTPUT_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PACKET_LENGTH: packet_length_q <= cfg_data_i[9:0];
        CFG_OUTPUT_LIMIT:  output_limit_q  <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // clamped limits
  logic [CW-1:0] plen;
  logic [8:0]    lim;
  logic [TW-1:0] maxc;

  assign plen = (CW'(packet_length_q) > CW'(PACKET_BYTES)) ? CW'(PACKET_BYTES)
                                                           : CW'(packet_length_q);
  assign lim  = (output_limit_q > 9'(NAME_MAX)) ? 9'(NAME_MAX) : output_limit_q;
  assign maxc = (lim == 9'd0) ? '0 : TW'(lim - 9'd1);

  // walk registers
  logic [PW-1:0] pos_q;
  logic [HW-1:0] hops_q;
  logic          jumped_q;
  logic          first_q;
  logic [9:0]    resume_q;
  logic [7:0]    byte_q;
  logic [7:0]    cnt_q;
  logic          rv_q;
  logic [1:0]    err_q;
  logic [TW-1:0] tlen_q;

  // packet store
  logic          pkt_we;
  logic [AW-1:0] pkt_waddr;
  logic          pkt_re;
  logic [CW-1:0] pkt_raddr_c;
  logic [7:0]    pkt_rdata;

  assign pkt_we      = cmd_i.load_wr && (CW'(in_data_i.byte_address) < CW'(PACKET_BYTES));
  assign pkt_waddr   = AW'(in_data_i.byte_address);
  assign pkt_re      = cmd_i.len_rd || cmd_i.ptr_rd || cmd_i.copy_rd;
  assign pkt_raddr_c = cmd_i.ptr_rd ? CW'(pos_q) + CW'(1) : CW'(pos_q);

  dnsd_ram #(
    .WIDTH (8),
    .DEPTH (PACKET_BYTES)
  ) u_pkt_ram (
    .clk_i   (clk_i),
    .we_i    (pkt_we),
    .waddr_i (pkt_waddr),
    .wdata_i (in_data_i.byte_value),
    .re_i    (pkt_re),
    .raddr_i (pkt_raddr_c[AW-1:0]),
    .rdata_o (pkt_rdata)
  );

  // bound and code checks on the walk
  logic [CW-1:0]  pos_c;
  logic [CW-1:0]  pos_p1;
  logic [15:0]    ptr_val;

  assign pos_c   = CW'(pos_q);
  assign pos_p1  = pos_c + CW'(1);
  assign ptr_val = {byte_q, pkt_rdata} & PTR_MASK;

  // text buffer writes: dots and label bytes, dropped past the limit
  logic          txt_we;
  logic [7:0]    txt_wdata;
  logic          room;

  assign room      = tlen_q < maxc;
  assign txt_we    = ((cmd_i.label_start && !first_q) || rv_q) && room;
  assign txt_wdata = rv_q ? pkt_rdata : DOT_CHAR;

  // emission registers
  logic [TW-1:0]   rd_idx_q;
  logic [3:0]      lane_q;
  logic            tv_q;
  logic [2:0]      tlane_q;
  logic [7:0][7:0] chunk_q;
  logic [7:0]      txt_rdata;
  logic            emit_last;
  logic            is_err;

  dnsd_ram #(
    .WIDTH (8),
    .DEPTH (NAME_MAX)
  ) u_txt_ram (
    .clk_i   (clk_i),
    .we_i    (txt_we),
    .waddr_i (tlen_q),
    .wdata_i (txt_wdata),
    .re_i    (cmd_i.fill_rd),
    .raddr_i (rd_idx_q),
    .rdata_o (txt_rdata)
  );

  assign emit_last = rd_idx_q == tlen_q;
  assign is_err    = err_q != STATUS_OK;

  // walk state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      hops_q   <= '0;
      jumped_q <= 1'b0;
      first_q  <= 1'b1;
      resume_q <= '0;
      cnt_q    <= '0;
      rv_q     <= 1'b0;
      err_q    <= STATUS_OK;
      tlen_q   <= '0;
    end else begin
      rv_q <= cmd_i.copy_rd;
      if (cmd_i.start) begin
        pos_q    <= PW'(in_data_i.start_offset);
        hops_q   <= '0;
        jumped_q <= 1'b0;
        first_q  <= 1'b1;
        resume_q <= '0;
        err_q    <= STATUS_OK;
        tlen_q   <= '0;
      end
      if (cmd_i.set_err) begin
        err_q <= cmd_i.err_code;
      end
      if (cmd_i.term && !jumped_q) begin
        resume_q <= pos_p1[9:0];
      end
      if (cmd_i.ptr_take) begin
        if (!jumped_q) begin
          resume_q <= 10'(pos_c + CW'(2));
          jumped_q <= 1'b1;
        end
        hops_q <= hops_q + HW'(1);
        pos_q  <= PW'(ptr_val);
      end
      if (cmd_i.label_start) begin
        first_q <= 1'b0;
        cnt_q   <= pkt_rdata;
        pos_q   <= pos_p1[PW-1:0];
      end
      if (cmd_i.copy_rd) begin
        cnt_q <= cnt_q - 8'd1;
        pos_q <= pos_p1[PW-1:0];
      end
      if (txt_we) begin
        tlen_q <= tlen_q + TW'(1);
      end
    end
  end

  // first pointer byte kept for the jump
  always_ff @(posedge clk_i) begin
    if (cmd_i.ptr_rd) begin
      byte_q <= pkt_rdata;
    end
  end

  // chunk assembly from the text buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
      lane_q   <= '0;
      tv_q     <= 1'b0;
      tlane_q  <= '0;
    end else begin
      tv_q <= cmd_i.fill_rd;
      if (cmd_i.emit_init) begin
        rd_idx_q <= '0;
      end
      if (cmd_i.chunk_clear) begin
        lane_q <= '0;
      end
      if (cmd_i.fill_rd) begin
        rd_idx_q <= rd_idx_q + TW'(1);
        lane_q   <= lane_q + 4'd1;
        tlane_q  <= lane_q[2:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.chunk_clear) begin
      chunk_q <= '0;
    end else if (tv_q) begin
      chunk_q[tlane_q] <= txt_rdata;
    end
  end

  // output register
  logic      out_valid_q;
  dnsd_out_t out_q;
  logic      out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_q.name_chunk    <= is_err ? 64'd0 : chunk_q;
      out_q.chunk_bytes   <= is_err ? 4'd0 : lane_q;
      out_q.last          <= is_err || emit_last;
      out_q.status        <= err_q;
      out_q.resume_offset <= (!is_err && emit_last) ? resume_q : 10'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // status to the controller
  always_comb begin
    sts_o           = '0;
    sts_o.pos_oob   = pos_c >= plen;
    sts_o.is_zero   = pkt_rdata == 8'd0;
    sts_o.is_ptr    = pkt_rdata >= PTR_MARK;
    sts_o.ptr_oob   = pos_p1 >= plen;
    sts_o.hop_lim   = hops_q >= HW'(MAX_HOPS);
    sts_o.label_oob = (pos_p1 + CW'(pkt_rdata)) > plen;
    sts_o.cnt_last  = cnt_q == 8'd1;
    sts_o.fill_more = (lane_q < 4'd8) && (rd_idx_q < tlen_q);
    sts_o.done      = is_err || emit_last;
    sts_o.out_free  = out_free;
  end

  // every packet read stays inside the valid packet bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_re |-> pkt_raddr_c < plen)
    else $error("packet read beyond packet length");

  // an error result carries no text and closes the decode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != STATUS_OK) |->
      (out_q.chunk_bytes == 4'd0 && out_q.last && out_q.resume_offset == 10'd0))
    else $error("error result with text");

  // every result but the last is a full chunk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.last) |-> out_q.chunk_bytes == 4'd8)
    else $error("short chunk before the last result");

endmodule

// File: rtl/dns_name_decompressor_core.sv
// dns_name_decompressor_core: top level of the dns name decompressor
// depends on dnsd_pkg, dnsd_ctrl, dnsd_dp and dnsd_ram
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_stall_o   in_data_i  (dnsd_in_t)
//   out       output     out_valid_o / out_stall_i out_data_o (dnsd_out_t)
//   cfg       input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// a load writes one packet byte; a decode reads each length byte, both pointer bytes
// and each label byte over the single packet ram read port, then reads the kept
// characters from the text buffer chunk by chunk; the output register holds a
// result while out_stall_i is high and the chunk emission waits on it; reset clears
// control state and the configuration registers only, the stores need no clearing
`timescale 1ns / 1ps

module dns_name_decompressor_core
  import dnsd_pkg::*;
#(
  parameter int unsigned PACKET_BYTES = 512,
  parameter int unsigned NAME_MAX     = 256,
  parameter int unsigned MAX_HOPS     = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  dnsd_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output dnsd_out_t             out_data_o
);

  dnsd_cmd_t cmd;
  dnsd_sts_t sts;

  // walk and emission sequencing
  dnsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.op),
    .busy_o     (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // stores, walk registers and output register
  dnsd_dp #(
    .PACKET_BYTES (PACKET_BYTES),
    .NAME_MAX     (NAME_MAX),
    .MAX_HOPS     (MAX_HOPS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: sim/tb_dns_name_decompressor_core.sv
// tb_dns_name_decompressor_core: self-checking bench for the dns name decompressor
// loads packet bytes, decodes names at random and directed offsets, and checks every chunk
// against a name walker kept in the bench; depends on dnsd_pkg and the core under rtl/
`timescale 1ns / 1ps

module tb_dns_name_decompressor_core;
  import dnsd_pkg::*;

  localparam int unsigned STORE_BYTES = 512;
  localparam int unsigned TEXT_MAX    = 256;
  localparam int unsigned HOP_MAX     = 16;
  localparam int unsigned IDLE_LIMIT  = 50000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned PHASES      = 7;
  localparam int unsigned PHASE_ITEMS = 40;
  // per phase register settings, phase 0 in the lowest slice
  localparam logic [10*PHASES-1:0] PLEN_PLAN =
    {10'd13, 10'd512, 10'd300, 10'd0, 10'd60, 10'd1023, 10'd512};
  localparam logic [10*PHASES-1:0] LIMIT_PLAN =
    {10'd40, 10'd9, 10'd0, 10'd1, 10'd12, 10'd511, 10'd256};

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  dnsd_in_t              in_data_i   = '0;
  logic                  out_stall_i = 1'b0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  dnsd_out_t             out_data_o;

  // bench side copy of the block state
  logic [7:0]  byte_mirror [STORE_BYTES];
  logic [9:0]  packet_len_cfg = PACKET_LENGTH_RST;
  logic [8:0]  out_lim_cfg    = OUTPUT_LIMIT_RST;
  dnsd_out_t   expected_chunks [$];

  // stimulus side shadow, used to keep decodes away from never written bytes
  logic [7:0]  gen_store [STORE_BYTES];
  bit          gen_written [STORE_BYTES];
  logic [8:0]  name_starts [$];
  dnsd_in_t    pending_items [$];
  int unsigned phase_items;
  bit          calm = 1'b0;
  int unsigned error_count = 0;

  dns_name_decompressor_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // idle length: mostly none, often short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one store byte, top bit flags a byte the stimulus never wrote
  function automatic logic [8:0] peek(input bit from_gen, input int unsigned addr);
    if (from_gen) return {~gen_written[addr], gen_store[addr]};
    return {1'b0, byte_mirror[addr]};
  endfunction

  // walk labels and pointers from start, collecting the dotted text
  function automatic logic [1:0] walk_name(input bit from_gen, input logic [8:0] start,
                                           output logic [2047:0] txt,
                                           output int unsigned tlen,
                                           output logic [9:0] resume, output bit blind);
    int unsigned plen, lim, maxc, pos, hops, i;
    bit          jumped, first, walking;
    logic [8:0]  rd;
    logic [7:0]  b;
    logic [1:0]  st;
    plen = (packet_len_cfg > STORE_BYTES) ? STORE_BYTES : packet_len_cfg;
    lim  = (out_lim_cfg > TEXT_MAX) ? TEXT_MAX : out_lim_cfg;
    if (lim < 1) lim = 1;
    maxc    = lim - 1;
    txt     = '0;
    tlen    = 0;
    resume  = '0;
    blind   = 1'b0;
    hops    = 0;
    jumped  = 1'b0;
    first   = 1'b1;
    walking = 1'b1;
    st      = STATUS_OK;
    pos     = 32'(start);
    while (walking) begin
      if (pos >= plen) begin
        st      = STATUS_OOB;
        walking = 1'b0;
      end else begin
        rd    = peek(from_gen, pos);
        blind = blind | rd[8];
        b     = rd[7:0];
        if (b == 8'h00) begin
          // terminating zero
          if (!jumped) resume = 10'(pos + 1);
          walking = 1'b0;
        end else if (b >= PTR_MARK) begin
          // compression pointer
          if (pos + 1 >= plen) begin
            st      = STATUS_OOB;
            walking = 1'b0;
          end else begin
            rd    = peek(from_gen, pos + 1);
            blind = blind | rd[8];
            if (hops >= HOP_MAX) begin
              st      = STATUS_HOPS;
              walking = 1'b0;
            end else begin
              if (!jumped) begin
                resume = 10'(pos + 2);
                jumped = 1'b1;
              end
              hops++;
              pos = 32'({b, rd[7:0]} & PTR_MASK);
            end
          end
        end else if (pos + 1 + b > plen) begin
          st      = STATUS_OOB;
          walking = 1'b0;
        end else begin
          // plain label, text past the limit is dropped
          if (!first && tlen < maxc) begin
            txt[8*tlen +: 8] = DOT_CHAR;
            tlen++;
          end
          first = 1'b0;
          for (i = 0; i < b; i++) begin
            rd    = peek(from_gen, pos + 1 + i);
            blind = blind | rd[8];
            if (tlen < maxc) begin
              txt[8*tlen +: 8] = rd[7:0];
              tlen++;
            end
          end
          pos = pos + 1 + b;
        end
      end
    end
    return st;
  endfunction

  // expected chunks of one decode
  function automatic void predict_decode(input logic [8:0] start);
    logic [2047:0] txt;
    int unsigned   tlen, nres, n, k;
    logic [9:0]    resume;
    bit            blind;
    logic [1:0]    st;
    dnsd_out_t     r;
    st = walk_name(1'b0, start, txt, tlen, resume, blind);
    if (st != STATUS_OK) begin
      r        = '0;
      r.last   = 1'b1;
      r.status = st;
      expected_chunks.push_back(r);
    end else begin
      nres = (tlen + 7) / 8;
      if (nres == 0) nres = 1;
      for (k = 0; k < nres; k++) begin
        n = (tlen > 8*k) ? tlen - 8*k : 0;
        if (n > 8) n = 8;
        r.name_chunk    = txt[64*k +: 64];
        r.chunk_bytes   = n[3:0];
        r.last          = (k + 1 == nres);
        r.status        = STATUS_OK;
        r.resume_offset = r.last ? resume : '0;
        expected_chunks.push_back(r);
      end
    end
  endfunction

  function automatic void add_load(input int unsigned addr, input logic [7:0] val);
    dnsd_in_t it;
    it.op           = OP_LOAD;
    it.byte_address = addr[8:0];
    it.byte_value   = val;
    it.start_offset = 9'($urandom_range(0, STORE_BYTES - 1));
    gen_store[addr]   = val;
    gen_written[addr] = 1'b1;
    pending_items.push_back(it);
    phase_items++;
  endfunction

  // queue a decode unless its walk would touch a never written byte
  function automatic void try_decode(input logic [8:0] start);
    logic [2047:0] txt;
    int unsigned   tlen;
    logic [9:0]    resume;
    bit            blind;
    dnsd_in_t      it;
    void'(walk_name(1'b1, start, txt, tlen, resume, blind));
    if (!blind) begin
      it.op           = OP_DECODE;
      it.byte_address = 9'($urandom_range(0, STORE_BYTES - 1));
      it.byte_value   = 8'($urandom_range(0, 255));
      it.start_offset = start;
      pending_items.push_back(it);
      phase_items++;
    end
  endfunction

  // well formed name: a few labels, then a zero or a pointer, then decode it
  function automatic void build_name();
    int unsigned base, p, nlab, len, n, i, r;
    logic [13:0] tgt;
    base = $urandom_range(0, STORE_BYTES - 3);
    p    = base;
    nlab = $urandom_range(0, 4);
    for (n = 0; n < nlab; n++) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 63) : $urandom_range(1, 8);
      if (p + 1 + len + 2 > STORE_BYTES) break;
      add_load(p, len[7:0]);
      for (i = 0; i < len; i++) add_load(p + 1 + i, 8'($urandom_range(0, 255)));
      p = p + 1 + len;
    end
    r = $urandom_range(0, 99);
    if (r < 50 || name_starts.size() == 0) begin
      add_load(p, 8'h00);
    end else begin
      if (r < 90) tgt = 14'(name_starts[$urandom_range(0, name_starts.size() - 1)]);
      else tgt = 14'($urandom_range(0, 14'h3FFF));
      add_load(p, PTR_MARK | {2'b00, tgt[13:8]});
      add_load(p + 1, tgt[7:0]);
    end
    name_starts.push_back(base[8:0]);
    try_decode(base[8:0]);
  endfunction

  // random phase: mostly fresh names and decodes of known names, some noise
  task automatic gen_phase(input int unsigned quota);
    int unsigned r;
    phase_items = 0;
    while (phase_items < quota) begin
      r = $urandom_range(0, 99);
      if (r < 40 || name_starts.size() == 0) build_name();
      else if (r < 75) try_decode(name_starts[$urandom_range(0, name_starts.size() - 1)]);
      else if (r < 87) try_decode(9'($urandom_range(0, STORE_BYTES - 1)));
      else add_load($urandom_range(0, STORE_BYTES - 1), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid_i || expected_chunks.size() != 0)
      @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    if (idx == CFG_PACKET_LENGTH) packet_len_cfg = val;
    else out_lim_cfg = val[8:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic check_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      error_count++;
    end
  endtask

  // sender: takes the next item when the slot is free, updates the prediction on transfer
  int unsigned send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap   = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        if (in_data_i.op == OP_LOAD) byte_mirror[in_data_i.byte_address] = in_data_i.byte_value;
        else predict_decode(in_data_i.start_offset);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap   = send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_data_i  <= pending_items.pop_front();
          in_valid_i <= 1'b1;
          send_gap   = calm ? 0 : pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result transfer, stalls at random, holds off once for long
  int unsigned stall_left = 0;
  int unsigned results_seen = 0;
  int unsigned hold_gap;
  bit          held_once = 1'b0;
  dnsd_out_t   want;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_chunks.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data_o);
          error_count++;
        end else begin
          want = expected_chunks.pop_front();
          check_field("name_chunk", want.name_chunk, out_data_o.name_chunk);
          check_field("chunk_bytes", 64'(want.chunk_bytes), 64'(out_data_o.chunk_bytes));
          check_field("last", 64'(want.last), 64'(out_data_o.last));
          check_field("status", 64'(want.status), 64'(out_data_o.status));
          check_field("resume_offset", 64'(want.resume_offset),
                      64'(out_data_o.resume_offset));
        end
      end
      if (!held_once && results_seen >= 25) begin
        held_once  = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left != 0) begin
        stall_left  = stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (calm) begin
        out_stall_i <= 1'b0;
      end else begin
        hold_gap = pick_gap();
        out_stall_i <= (hold_gap != 0);
        if (hold_gap != 0) stall_left = hold_gap - 1;
      end
    end
  end

  // watchdog on cycles without any transfer
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, expected_chunks.size());
        $display("FAIL dns_name_decompressor_core");
        $finish;
      end
    end
  end

  // main sequence
  int unsigned ph;
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // root name
    add_load(0, 8'h00);
    try_decode(0);
    // "abc" closed by a pointer back to the root
    add_load(1, 8'h03);
    add_load(2, 8'h61);
    add_load(3, 8'h62);
    add_load(4, 8'h63);
    add_load(5, PTR_MARK);
    add_load(6, 8'h00);
    try_decode(1);
    // pointer to itself runs into the hop limit
    add_load(7, PTR_MARK);
    add_load(8, 8'h07);
    try_decode(7);
    // length byte in the 0x40..0xbf range, label runs past the end
    add_load(400, 8'h80);
    try_decode(400);
    // label overrun on the last byte
    add_load(511, 8'h05);
    try_decode(511);
    // pointer whose second byte lies past the end
    add_load(511, 8'hFF);
    try_decode(511);
    wait_idle();

    // truncation, then empty text at an output limit of 1
    write_reg(CFG_OUTPUT_LIMIT, 10'd3);
    try_decode(1);
    wait_idle();
    write_reg(CFG_OUTPUT_LIMIT, 10'd1);
    try_decode(1);
    wait_idle();

    for (ph = 0; ph < PHASES; ph++) begin
      write_reg(CFG_PACKET_LENGTH, PLEN_PLAN[10*ph +: 10]);
      write_reg(CFG_OUTPUT_LIMIT, LIMIT_PLAN[10*ph +: 10]);
      calm = (ph == 5);
      gen_phase(PHASE_ITEMS);
      wait_idle();
    end

    repeat (50) @(negedge clk_i);
    if (error_count == 0) begin
      $display("PASS dns_name_decompressor_core");
    end else begin
      $display("FAIL dns_name_decompressor_core");
    end
    $finish;
  end

endmodule
